// File: sv/mwaf_pkg.sv
package mwaf_pkg;

  localparam int WINDOW_LEN_DEF   = 8;
  localparam int QUEUE_DEPTH      = 4;
  localparam int DIV_DW           = 50;
  localparam int DIV_VW           = 26;
  localparam int DIV_STEPS_WIDE   = 50;
  localparam int DIV_STEPS_NARROW = 32;
  localparam int DIV_CNT_W        = 6;
  localparam int ACC_W            = 41;
  localparam int SUMW_W           = 23;

  localparam logic [2:0] CFG_FLOOR   = 3'd0;
  localparam logic [2:0] CFG_CEILING = 3'd1;
  localparam logic [2:0] CFG_HISTORY = 3'd2;
  localparam logic [2:0] CFG_DECAY   = 3'd3;
  localparam logic [2:0] CFG_MEDIAN  = 3'd4;

  typedef enum logic [1:0] {
    ORIGIN_NEW   = 2'd0,
    ORIGIN_HELD  = 2'd1,
    ORIGIN_CLAMP = 2'd2
  } origin_t;

  typedef struct packed {
    origin_t            kind;
    logic signed [15:0] value;
  } job_t;

  typedef struct packed {
    logic signed [15:0] floor_v;
    logic signed [15:0] ceil_v;
    logic [15:0]        hist_w;
    logic [15:0]        decay;
    logic               median_only;
  } cfg_t;

  typedef struct packed {
    logic              go;
    logic              narrow;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    B_IDLE, B_WIN, B_WDIV, B_WWAIT, B_MUL, B_ACC,
    B_PP, B_NUM, B_MAG, B_FDIV, B_FWAIT, B_DONE
  } back_state_t;

  // Q16.8 average to a 16-bit sample, rounded to nearest with ties away from zero.
  function automatic logic signed [15:0] avg_to_out(input logic signed [23:0] a);
    logic        neg;
    logic [23:0] mag;
    logic [16:0] q;
    neg = a[23];
    mag = neg ? 24'(24'd0 - a) : a;
    q   = 17'((25'(mag) + 25'd128) >> 8);
    if (!neg) begin
      return (q > 17'd32767) ? 16'sh7FFF : $signed(q[15:0]);
    end
    return (q > 17'd32768) ? 16'sh8000 : $signed(16'(17'd0 - q));
  endfunction

endpackage

// File: sv/median3_weighted_average_filter.sv
// Clamped and held items are presented straight from the queue head when the back end is idle.
// A group-closing item passes one division in median mode and, in window mode, one weight division
// per valid window entry before the final one; the shared serial divider does them all.
// Throughput: the back end runs one item at a time; a four-item queue takes input meanwhile.
// Reset (synchronous, active low) restores register defaults and empties group,
// window fill and average; window contents stay undefined until written.
module median3_weighted_average_filter #(
  parameter int WINDOW_LEN = mwaf_pkg::WINDOW_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // filtered
  output logic [1:0]  out_tuser,  // origin_code
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  mwaf_pkg::cfg_t cfg_r;
  logic           push;
  mwaf_pkg::job_t push_job;
  logic           q_full;
  logic           q_empty;
  logic           pop;
  mwaf_pkg::job_t head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{floor_v: 16'sh8000, ceil_v: 16'sh7FFF, hist_w: 16'd256,
                 decay: 16'd256, median_only: 1'b0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        mwaf_pkg::CFG_FLOOR:   cfg_r.floor_v     <= $signed(cfg_wdata);
        mwaf_pkg::CFG_CEILING: cfg_r.ceil_v      <= $signed(cfg_wdata);
        mwaf_pkg::CFG_HISTORY: cfg_r.hist_w      <= cfg_wdata;
        mwaf_pkg::CFG_DECAY:   cfg_r.decay       <= cfg_wdata;
        mwaf_pkg::CFG_MEDIAN:  cfg_r.median_only <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  mwaf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg       (cfg_r),
    .push      (push),
    .push_job  (push_job),
    .q_full    (q_full)
  );

  mwaf_queue #(.DEPTH(mwaf_pkg::QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  mwaf_back #(.WINDOW_LEN(WINDOW_LEN)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: sv/mwaf_front.sv
module mwaf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [15:0]         in_tdata,
  input  mwaf_pkg::cfg_t      cfg,
  output logic                push,
  output mwaf_pkg::job_t      push_job,
  input  logic                q_full
);

  logic               acc;
  logic               in_range;
  logic signed [15:0] x;
  logic signed [15:0] t0_r;
  logic signed [15:0] t1_r;
  logic [1:0]         cnt_r;
  logic signed [15:0] lo;
  logic signed [15:0] hi;
  logic signed [15:0] mid;
  logic signed [15:0] med;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign push      = acc;
  assign x         = $signed(in_tdata);
  assign in_range  = !(x < cfg.floor_v) && !(x > cfg.ceil_v);

  always_comb begin
    lo  = (t0_r < t1_r) ? t0_r : t1_r;
    hi  = (t0_r < t1_r) ? t1_r : t0_r;
    mid = (hi < x) ? hi : x;
    med = (lo > mid) ? lo : mid;
    priority if (x < cfg.floor_v) begin
      push_job = '{kind: mwaf_pkg::ORIGIN_CLAMP, value: cfg.floor_v};
    end else if (x > cfg.ceil_v) begin
      push_job = '{kind: mwaf_pkg::ORIGIN_CLAMP, value: cfg.ceil_v};
    end else if (cnt_r < 2'd2) begin
      push_job = '{kind: mwaf_pkg::ORIGIN_HELD, value: 16'sd0};
    end else begin
      push_job = '{kind: mwaf_pkg::ORIGIN_NEW, value: med};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (acc && in_range) begin
      if (cnt_r == 2'd0) begin
        t0_r  <= x;
        cnt_r <= 2'd1;
      end else if (cnt_r == 2'd1) begin
        t1_r  <= x;
        cnt_r <= 2'd2;
      end else begin
        cnt_r <= 2'd0;
      end
    end
  end

endmodule

// File: sv/mwaf_queue.sv
module mwaf_queue #(
  parameter int DEPTH = mwaf_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mwaf_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output mwaf_pkg::job_t head,
  output logic           empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mwaf_pkg::job_t entry_r [DEPTH];
  logic [AW-1:0]  wp_r;
  logic [AW-1:0]  rp_r;
  logic [CW-1:0]  cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = entry_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        entry_r[wp_r] <= push_job;
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: sv/mwaf_div.sv
module mwaf_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mwaf_pkg::div_req_t            req,
  output logic                          done,
  output logic [mwaf_pkg::DIV_DW-1:0]   quotient
);

  localparam int DW = mwaf_pkg::DIV_DW;
  localparam int VW = mwaf_pkg::DIV_VW;

  logic [DW-1:0]                  q_r;
  logic [VW-1:0]                  rem_r;
  logic [VW-1:0]                  dvs_r;
  logic [mwaf_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;
  logic [VW:0]                    trial;
  logic                           fits;

  assign trial    = {rem_r, q_r[DW-1]};
  assign fits     = (trial >= {1'b0, dvs_r});
  assign done     = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        q_r    <= req.dividend;
        dvs_r  <= req.divisor;
        rem_r  <= '0;
        busy_r <= 1'b1;
        cnt_r  <= req.narrow ? mwaf_pkg::DIV_CNT_W'(mwaf_pkg::DIV_STEPS_NARROW)
                             : mwaf_pkg::DIV_CNT_W'(mwaf_pkg::DIV_STEPS_WIDE);
      end else if (busy_r) begin
        rem_r <= fits ? VW'(trial - {1'b0, dvs_r}) : trial[VW-1:0];
        q_r   <= {q_r[DW-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == mwaf_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/mwaf_back.sv
module mwaf_back #(
  parameter int WINDOW_LEN = mwaf_pkg::WINDOW_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mwaf_pkg::cfg_t cfg,
  input  logic           q_empty,
  input  mwaf_pkg::job_t head,
  output logic           pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [15:0]    out_tdata,
  output logic [1:0]     out_tuser
);

  localparam int IW  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int FW  = $clog2(WINDOW_LEN + 1);
  localparam int DW  = mwaf_pkg::DIV_DW;
  localparam int VW  = mwaf_pkg::DIV_VW;
  localparam int AW  = mwaf_pkg::ACC_W;
  localparam int SWW = mwaf_pkg::SUMW_W;

  mwaf_pkg::back_state_t state_r, state_nxt;
  mwaf_pkg::div_req_t    div_req;
  logic                  div_done;
  logic [DW-1:0]         div_q;

  logic signed [15:0]    win_mem [WINDOW_LEN];
  logic signed [15:0]    rd_data_r;
  logic [IW-1:0]         wp_r;
  logic [IW-1:0]         rd_ptr_r;
  logic [FW-1:0]         fill_r;
  logic [FW-1:0]         k_r;
  logic signed [15:0]    med_r;
  logic [16:0]           w_r;
  logic signed [33:0]    prod_r;
  logic signed [AW-1:0]  sum_l_r;
  logic [SWW-1:0]        sum_w_r;
  logic signed [40:0]    pp_r;
  logic signed [41:0]    num_r;
  logic [VW-1:0]         den_r;
  logic                  neg_r;
  logic [DW-1:0]         mag_r;
  logic signed [23:0]    prev_r;
  logic                  out_valid_r;
  logic [15:0]           out_data_r;
  mwaf_pkg::origin_t     out_origin_r;
  logic [15:0]           af;
  logic [16:0]           den_k;
  logic signed [49:0]    num256;
  logic                  last_k;

  assign af         = (cfg.decay == 16'd0) ? 16'd1 : cfg.decay;
  assign den_k      = 17'(af) + 17'({k_r, 8'b0});
  assign num256     = {num_r, 8'b0};
  assign last_k     = (k_r == FW'(fill_r - 1'b1));
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_origin_r;

  mwaf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mwaf_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    div_req   = '{go: 1'b0, narrow: 1'b0, dividend: '0, divisor: '0};
    unique case (state_r)
      mwaf_pkg::B_IDLE: begin
        if (!q_empty && !out_valid_r) begin
          pop = 1'b1;
          if (head.kind == mwaf_pkg::ORIGIN_NEW) begin
            state_nxt = cfg.median_only ? mwaf_pkg::B_PP : mwaf_pkg::B_WIN;
          end
        end
      end
      mwaf_pkg::B_WIN:   state_nxt = mwaf_pkg::B_WDIV;
      mwaf_pkg::B_WDIV: begin
        div_req   = '{go: 1'b1, narrow: 1'b1,
                      dividend: {af, den_k[16:1], 18'b0}, divisor: VW'(den_k)};
        state_nxt = mwaf_pkg::B_WWAIT;
      end
      mwaf_pkg::B_WWAIT: if (div_done) state_nxt = mwaf_pkg::B_MUL;
      mwaf_pkg::B_MUL:   state_nxt = mwaf_pkg::B_ACC;
      mwaf_pkg::B_ACC:   state_nxt = last_k ? mwaf_pkg::B_PP : mwaf_pkg::B_WDIV;
      mwaf_pkg::B_PP:    state_nxt = mwaf_pkg::B_NUM;
      mwaf_pkg::B_NUM:   state_nxt = mwaf_pkg::B_MAG;
      mwaf_pkg::B_MAG:   state_nxt = mwaf_pkg::B_FDIV;
      mwaf_pkg::B_FDIV: begin
        div_req   = '{go: 1'b1, narrow: 1'b0,
                      dividend: mag_r + DW'(den_r >> 1), divisor: den_r};
        state_nxt = mwaf_pkg::B_FWAIT;
      end
      mwaf_pkg::B_FWAIT: if (div_done) state_nxt = mwaf_pkg::B_DONE;
      mwaf_pkg::B_DONE:  state_nxt = mwaf_pkg::B_IDLE;
      default:           state_nxt = mwaf_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data_r <= win_mem[rd_ptr_r];
    if (state_r == mwaf_pkg::B_WIN) begin
      win_mem[wp_r] <= med_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      fill_r      <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        mwaf_pkg::B_IDLE: begin
          if (pop) begin
            med_r   <= head.value;
            sum_l_r <= AW'($signed({head.value, 16'b0}));
            sum_w_r <= SWW'(65536);
            if (head.kind == mwaf_pkg::ORIGIN_CLAMP) begin
              out_data_r   <= head.value;
              out_origin_r <= mwaf_pkg::ORIGIN_CLAMP;
              out_valid_r  <= 1'b1;
            end else if (head.kind == mwaf_pkg::ORIGIN_HELD) begin
              out_data_r   <= mwaf_pkg::avg_to_out(prev_r);
              out_origin_r <= mwaf_pkg::ORIGIN_HELD;
              out_valid_r  <= 1'b1;
            end
          end
        end
        mwaf_pkg::B_WIN: begin
          rd_ptr_r <= wp_r;
          wp_r     <= (wp_r == IW'(WINDOW_LEN - 1)) ? '0 : wp_r + 1'b1;
          fill_r   <= (fill_r == FW'(WINDOW_LEN)) ? fill_r : fill_r + 1'b1;
          k_r      <= '0;
          sum_l_r  <= '0;
          sum_w_r  <= '0;
        end
        mwaf_pkg::B_WWAIT: begin
          if (div_done) begin
            w_r <= div_q[16:0];
          end
        end
        mwaf_pkg::B_MUL: begin
          prod_r <= $signed({1'b0, w_r}) * rd_data_r;
        end
        mwaf_pkg::B_ACC: begin
          sum_l_r  <= sum_l_r + AW'(prod_r);
          sum_w_r  <= sum_w_r + SWW'(w_r);
          k_r      <= k_r + 1'b1;
          rd_ptr_r <= (rd_ptr_r == '0) ? IW'(WINDOW_LEN - 1) : rd_ptr_r - 1'b1;
        end
        mwaf_pkg::B_PP: begin
          pp_r <= prev_r * $signed({1'b0, cfg.hist_w});
        end
        mwaf_pkg::B_NUM: begin
          num_r <= 42'(sum_l_r) + 42'(pp_r);
          den_r <= VW'(sum_w_r) + VW'({cfg.hist_w, 8'b0});
        end
        mwaf_pkg::B_MAG: begin
          neg_r <= num_r[41];
          mag_r <= num_r[41] ? DW'(50'sd0 - num256) : DW'(num256);
        end
        mwaf_pkg::B_FDIV: begin
        end
        mwaf_pkg::B_FWAIT: begin
          if (div_done) begin
            if (!neg_r) begin
              prev_r <= (div_q > DW'(8388607)) ? 24'sh7FFFFF : $signed(div_q[23:0]);
            end else begin
              prev_r <= (div_q > DW'(8388608)) ? 24'sh800000
                                               : $signed(24'(24'd0 - div_q[23:0]));
            end
          end
        end
        mwaf_pkg::B_DONE: begin
          out_data_r   <= mwaf_pkg::avg_to_out(prev_r);
          out_origin_r <= mwaf_pkg::ORIGIN_NEW;
          out_valid_r  <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !out_valid_r)
    else $error("item taken from queue while the output register is full");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(WINDOW_LEN))
    else $error("window fill count beyond window length");
  a_final_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mwaf_pkg::B_FWAIT && div_done) |=> (state_r == mwaf_pkg::B_DONE))
    else $error("final division did not lead to the result");
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mwaf_pkg::B_DONE) |=> out_valid_r)
    else $error("computed average not presented");
`endif

endmodule

// File: tb/sv/tb_median3_weighted_average_filter.sv
`timescale 1ns / 100ps

module tb_median3_weighted_average_filter;

  localparam int WLEN = 8;
  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // sample
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // filtered
  logic [1:0]  out_tuser;  // origin_code
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  median3_weighted_average_filter dut (.*);

  typedef struct packed {
    logic [15:0]          value;
    mwaf_pkg::origin_t    kind;
  } filt_result_t;

  // Shadow of the filter configuration and state.
  logic signed [15:0] lo_bound, hi_bound;
  logic [15:0]        hist_w, decay;
  logic               med_mode;
  logic signed [15:0] group_buf [3];
  int                 group_cnt;
  logic signed [15:0] ring [WLEN];
  int                 ring_fill, ring_wr;
  longint             avg_q;

  logic [15:0]  sample_queue [$];
  filt_result_t expected_results [$];
  int           errors;
  int           quiet_cycles;
  bit           driver_hold, no_idle;
  bit           in_fire;
  int           src_gap, sink_gap, sink_hold_cnt;
  int           sent_items;

  function automatic longint rnd_div(longint n, longint d);
    longint m, q;
    m = (n < 0) ? -n : n;
    q = (m + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic logic [15:0] avg_to_sample(longint a);
    longint r;
    r = rnd_div(a, 256);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function automatic filt_result_t filter_sample(logic [15:0] raw);
    logic signed [15:0] x;
    longint lo, hi, t, med, num, den, sum_l, sum_w, af, w, p;
    int idx;
    filt_result_t r;
    x = $signed(raw);
    if (x < lo_bound || x > hi_bound) begin
      r.value = (x < lo_bound) ? lo_bound : hi_bound;
      r.kind = mwaf_pkg::ORIGIN_CLAMP;
      return r;
    end
    group_buf[group_cnt] = x;
    if (group_cnt < 2) begin
      group_cnt++;
      r.value = avg_to_sample(avg_q);
      r.kind = mwaf_pkg::ORIGIN_HELD;
      return r;
    end
    group_cnt = 0;
    lo = (group_buf[0] < group_buf[1]) ? group_buf[0] : group_buf[1];
    hi = (group_buf[0] < group_buf[1]) ? group_buf[1] : group_buf[0];
    t = (hi < group_buf[2]) ? hi : longint'(group_buf[2]);
    med = (lo > t) ? lo : t;
    p = hist_w;
    if (med_mode) begin
      num = med * 65536 + avg_q * p;
      den = 65536 + 256 * p;
    end else begin
      af = (decay == 0) ? 1 : decay;
      ring[ring_wr] = med;
      ring_wr = (ring_wr + 1) % WLEN;
      if (ring_fill < WLEN) ring_fill++;
      sum_l = 0;
      sum_w = 0;
      for (int k = 0; k < ring_fill; k++) begin
        w = rnd_div(af * 65536, af + 256 * k);
        idx = (ring_wr + 2 * WLEN - 1 - k) % WLEN;
        sum_l += w * ring[idx];
        sum_w += w;
      end
      num = sum_l + avg_q * p;
      den = sum_w + 256 * p;
    end
    avg_q = rnd_div(num * 256, den);
    if (avg_q > 8388607) avg_q = 8388607;
    if (avg_q < -8388608) avg_q = -8388608;
    r.value = avg_to_sample(avg_q);
    r.kind = mwaf_pkg::ORIGIN_NEW;
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Driver: offers queued items, with random idle bursts, and drives the receiver ready with random stalls.
  always @(negedge clk) begin
    if (in_fire) begin
      void'(sample_queue.pop_front());
      sent_items++;
    end
    if (src_gap > 0) src_gap--;
    if (!no_idle && src_gap == 0 && $urandom_range(0, 15) == 0)
      src_gap = $urandom_range(1, 14);
    if (rst_n && !driver_hold && sample_queue.size() > 0 && src_gap == 0) begin
      in_tvalid <= 1'b1;
      in_tdata  <= sample_queue[0];
    end else begin
      in_tvalid <= 1'b0;
    end
    if (sink_hold_cnt > 0) begin
      sink_hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      if (sink_gap > 0) sink_gap--;
      if (!no_idle && sink_gap == 0 && $urandom_range(0, 15) == 0)
        sink_gap = $urandom_range(1, 14);
      out_tready <= rst_n && sink_gap == 0;
    end
  end

  // Monitor: predicts on input acceptance, checks on output acceptance.
  always @(posedge clk) begin
    filt_result_t got, want;
    in_fire = in_tvalid && in_tready;
    if (rst_n) begin
      if (in_fire) begin
        expected_results.push_back(filter_sample(in_tdata));
      end
      if (in_fire || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_tvalid && out_tready) begin
        got.value = out_tdata;
        got.kind = mwaf_pkg::origin_t'(out_tuser);
        if (expected_results.size() == 0) begin
          $error("unexpected result filtered=%0d origin=%0d", $signed(out_tdata), out_tuser);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.value !== want.value) begin
            $error("filtered: expected %0d, got %0d", $signed(want.value),
                   $signed(got.value));
            errors++;
          end
          if (got.kind !== want.kind) begin
            $error("origin_code: expected %0d, got %0d", want.kind, got.kind);
            errors++;
          end
        end
      end
      if (quiet_cycles > STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mwaf_pkg::CFG_FLOOR:   lo_bound = val;
      mwaf_pkg::CFG_CEILING: hi_bound = val;
      mwaf_pkg::CFG_HISTORY: hist_w = val;
      mwaf_pkg::CFG_DECAY:   decay = val;
      mwaf_pkg::CFG_MEDIAN:  med_mode = val[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (sample_queue.size() == 0 && expected_results.size() == 0);
    repeat (400) @(negedge clk);
  endtask

  task automatic push_random_samples(int n, bit in_range);
    int v;
    for (int i = 0; i < n; i++) begin
      if (in_range && $urandom_range(0, 9) != 0)
        v = int'($urandom_range(0, int'(hi_bound) - int'(lo_bound))) + int'(lo_bound);
      else
        v = $urandom_range(0, 65535);
      sample_queue.push_back(16'(v));
    end
  endtask

  initial begin
    logic [15:0] directed [] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h7FFF,
                                 16'h8000, 16'h8000, 16'h8000, 16'h0005, 16'h0005,
                                 16'h0005, 16'hFFFF, 16'h1234, 16'hAAAA, 16'h5555};
    in_tvalid = 0; in_tdata = 0; out_tready = 0;
    cfg_we = 0; cfg_index = mwaf_pkg::CFG_FLOOR; cfg_wdata = 0;
    rst_n = 0;
    errors = 0; quiet_cycles = 0; sent_items = 0;
    driver_hold = 0; no_idle = 0; src_gap = 0; sink_gap = 0; sink_hold_cnt = 0;
    lo_bound = -32768; hi_bound = 32767; hist_w = 256; decay = 256; med_mode = 0;
    group_cnt = 0; ring_fill = 0; ring_wr = 0; avg_q = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    foreach (directed[i]) sample_queue.push_back(directed[i]);
    drain();

    // Receiver stalls long while the sender keeps offering.
    sink_hold_cnt = 600;
    push_random_samples(30, 1);
    wait (sink_hold_cnt == 0);
    drain();

    write_reg(mwaf_pkg::CFG_FLOOR, 16'(-1000));
    write_reg(mwaf_pkg::CFG_CEILING, 16'd1000);
    write_reg(mwaf_pkg::CFG_HISTORY, 16'd0);
    write_reg(mwaf_pkg::CFG_DECAY, 16'd0);
    sample_queue.push_back(16'(-1001));
    sample_queue.push_back(16'd1001);
    push_random_samples(120, 1);
    drain();

    write_reg(mwaf_pkg::CFG_MEDIAN, 16'd1);
    write_reg(mwaf_pkg::CFG_HISTORY, 16'hFFFF);
    write_reg(mwaf_pkg::CFG_FLOOR, 16'h8000);
    write_reg(mwaf_pkg::CFG_CEILING, 16'h7FFF);
    push_random_samples(150, 1);
    drain();

    write_reg(mwaf_pkg::CFG_HISTORY, 16'd64);
    write_reg(mwaf_pkg::CFG_FLOOR, 16'd500);
    write_reg(mwaf_pkg::CFG_CEILING, 16'(-500));
    push_random_samples(40, 0);
    drain();

    write_reg(mwaf_pkg::CFG_MEDIAN, 16'd0);
    write_reg(mwaf_pkg::CFG_DECAY, 16'hFFFF);
    write_reg(mwaf_pkg::CFG_FLOOR, 16'h8000);
    write_reg(mwaf_pkg::CFG_CEILING, 16'h7FFF);
    write_reg(mwaf_pkg::CFG_HISTORY, 16'd300);
    push_random_samples(200, 1);
    drain();

    write_reg(mwaf_pkg::CFG_DECAY, 16'd1);
    write_reg(mwaf_pkg::CFG_HISTORY, 16'd128);
    write_reg(mwaf_pkg::CFG_FLOOR, 16'(-20000));
    write_reg(mwaf_pkg::CFG_CEILING, 16'd20000);
    push_random_samples(200, 1);
    drain();

    write_reg(mwaf_pkg::CFG_DECAY, 16'd700);
    no_idle = 1;
    push_random_samples(200, 1);
    wait (sample_queue.size() == 0);
    wait (expected_results.size() == 0);
    repeat (400) @(negedge clk);

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
